// ===== rtl/assert_macros.svh =====
// assertion macros used by the detector top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/wtvd_pkg.sv =====
// package: constants and register codes of the trend vote detector
package wtvd_pkg;

    localparam int WINDOW_LEN_DEF = 5;

    localparam int IN_BITS     = 50;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int CNT_OUT_W   = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VOTES_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETX_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTES     = 3'd4;

    localparam logic [15:0]        NO_PARENT_ETX     = 16'd128;
    localparam logic [15:0]        RANK_THR_RST      = 16'd128;
    localparam logic [15:0]        ETX_THR_RST       = 16'd128;
    localparam logic [15:0]        RX_HIGH_RST       = 16'd150;
    localparam logic [15:0]        RX_LOW_RST        = 16'd15;
    localparam logic [VOTES_W-1:0] VOTES_RST         = 3'd3;

endpackage

// ===== rtl/windowed_trend_vote_detector_unit.sv =====
// top level: sliding-window trend vote detector with input and result registers
// a word's result enters the result register when that one is empty or being read
// throughput: one word per cycle unless the result side stalls; window work settles
//   between input and result register, the window itself updates once per word
// reset (i_rst_n low, synchronous): both stages empty, window empty, first tick
//   not yet seen, sensor mode, thresholds back to 128/128/150/15 and 3 votes
`include "assert_macros.svh"

module windowed_trend_vote_detector_unit
    import wtvd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // instance_present, node_rank[16], parent_present, link_etx[16], rx_total[16]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // window_full, rank_rises[3], etx_rises[3], busy_ticks[3], quiet_ticks[3],
    // activate, deactivate, sink_mode
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int CMP_W  = (CNT_W > VOTES_W) ? CNT_W : VOTES_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);

    // configuration
    logic [15:0]        r_rank_thr, r_etx_thr, r_rx_high, r_rx_low;
    logic [VOTES_W-1:0] r_votes;

    // pipeline stages
    logic                   r_in_valid;
    logic [IN_BITS-1:0]     r_in_data;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   advance;

    // detector state
    logic              r_seen;
    logic [FILL_W-1:0] r_fill;
    logic [15:0]       r_rank_win [WINDOW_LEN];
    logic [15:0]       r_etx_win  [WINDOW_LEN];
    logic [15:0]       r_rx_win   [WINDOW_LEN];
    logic [15:0]       r_prev_rx;
    logic              r_mode;

    logic              n_fill;
    logic [FILL_W-1:0] n_fill_lvl;
    logic [15:0]       n_rank_win [WINDOW_LEN];
    logic [15:0]       n_etx_win  [WINDOW_LEN];
    logic [15:0]       n_rx_win   [WINDOW_LEN];
    logic [15:0]       n_prev_rx;
    logic              n_mode;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // decoded word and working values
    logic              present, parent;
    logic [15:0]       rank, etx_raw, etx, rx, delta;
    logic              wr_en, full, act, deact;
    logic [FILL_W-1:0] fill_inc, fill_after;
    logic [15:0]       s_rank [WINDOW_LEN];
    logic [15:0]       s_etx  [WINDOW_LEN];
    logic [15:0]       s_rx   [WINDOW_LEN];
    logic [CNT_W-1:0]  rr, er, busy, quiet;
    logic [CMP_W-1:0]  rr_x, er_x, busy_x, quiet_x, votes_x;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign present = r_in_data[0];
    assign rank    = r_in_data[16:1];
    assign parent  = r_in_data[17];
    assign etx_raw = r_in_data[33:18];
    assign rx      = r_in_data[49:34];
    assign etx     = parent ? etx_raw : NO_PARENT_ETX;
    assign delta   = rx - r_prev_rx;

    always_comb begin
        wr_en    = present && r_seen && (r_fill < FILL_FULL);
        fill_inc = wr_en ? r_fill + FILL_W'(1) : r_fill;
        full     = present && (fill_inc == FILL_FULL);

        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (wr_en && r_fill == FILL_W'(i)) begin
                s_rank[i] = rank;
                s_etx[i]  = etx;
                s_rx[i]   = delta;
            end else begin
                s_rank[i] = r_rank_win[i];
                s_etx[i]  = r_etx_win[i];
                s_rx[i]   = r_rx_win[i];
            end
        end

        // a full window slides and takes the new sample as newest, which stores
        // the filling sample twice
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            n_rank_win[i] = full ? s_rank[i+1] : s_rank[i];
            n_etx_win[i]  = full ? s_etx[i+1]  : s_etx[i];
            n_rx_win[i]   = full ? s_rx[i+1]   : s_rx[i];
        end
        n_rank_win[WINDOW_LEN-1] = full ? rank  : s_rank[WINDOW_LEN-1];
        n_etx_win[WINDOW_LEN-1]  = full ? etx   : s_etx[WINDOW_LEN-1];
        n_rx_win[WINDOW_LEN-1]   = full ? delta : s_rx[WINDOW_LEN-1];

        rr    = '0;
        er    = '0;
        busy  = '0;
        quiet = '0;
        if (full) begin
            for (int i = 1; i < WINDOW_LEN; i++) begin
                if ({1'b0, n_rank_win[i]} >= {1'b0, n_rank_win[0]} + {1'b0, r_rank_thr})
                    rr = rr + CNT_W'(1);
                if ({1'b0, n_etx_win[i]} >= {1'b0, n_etx_win[0]} + {1'b0, r_etx_thr})
                    er = er + CNT_W'(1);
            end
            for (int i = 0; i < WINDOW_LEN; i++) begin
                if (n_rx_win[i] >= r_rx_high)
                    busy = busy + CNT_W'(1);
                if (n_rx_win[i] <= r_rx_low)
                    quiet = quiet + CNT_W'(1);
            end
        end

        rr_x    = CMP_W'(rr);
        er_x    = CMP_W'(er);
        busy_x  = CMP_W'(busy);
        quiet_x = CMP_W'(quiet);
        votes_x = CMP_W'(r_votes);

        // activation wins; once it fires the window is empty and no quiet vote
        act        = full && (rr_x >= votes_x) && !r_mode;
        fill_after = act ? '0 : fill_inc;
        deact      = present && (fill_after == FILL_FULL) && (quiet_x >= votes_x) && r_mode;
        n_fill_lvl = deact ? '0 : fill_after;
        n_fill     = 1'b1;

        if (act)
            n_mode = 1'b1;
        else if (deact)
            n_mode = 1'b0;
        else
            n_mode = r_mode;

        n_prev_rx = present ? rx : r_prev_rx;

        n_out_data = {n_mode, deact, act, quiet_x[CNT_OUT_W-1:0], busy_x[CNT_OUT_W-1:0],
                      er_x[CNT_OUT_W-1:0], rr_x[CNT_OUT_W-1:0], full};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_thr <= RANK_THR_RST;
            r_etx_thr  <= ETX_THR_RST;
            r_rx_high  <= RX_HIGH_RST;
            r_rx_low   <= RX_LOW_RST;
            r_votes    <= VOTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANK_THR: r_rank_thr <= i_cfg_data;
                CFG_ETX_THR:  r_etx_thr  <= i_cfg_data;
                CFG_RX_HIGH:  r_rx_high  <= i_cfg_data;
                CFG_RX_LOW:   r_rx_low   <= i_cfg_data;
                CFG_VOTES:    r_votes    <= i_cfg_data[VOTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
            r_fill      <= '0;
            r_prev_rx   <= '0;
            r_mode      <= 1'b0;
        end else begin
            if (o_s_tready)
                r_in_valid <= i_s_tvalid;
            if (advance)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
            if (advance) begin
                r_seen    <= n_fill;
                r_fill    <= n_fill_lvl;
                r_prev_rx <= n_prev_rx;
                r_mode    <= n_mode;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid)
            r_in_data <= i_s_tdata[IN_BITS-1:0];
        if (advance) begin
            r_out_data <= n_out_data;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_rank_win[i] <= n_rank_win[i];
                r_etx_win[i]  <= n_etx_win[i];
                r_rx_win[i]   <= n_rx_win[i];
            end
        end
    end

    `ASSERT_CLK(a_no_double_pulse, r_out_valid |-> !(r_out_data[13] && r_out_data[14]), "activate and deactivate in one word")
    `ASSERT_CLK(a_counts_need_full, (r_out_valid && !r_out_data[0]) |-> (r_out_data[12:1] == '0), "counts without a full window")
    `ASSERT_CLK(a_fill_bound, r_fill <= FILL_FULL, "fill level beyond window length")
    `ASSERT_CLK(a_mode_moves_on_word, (r_mode != $past(r_mode)) |-> $past(advance), "mode changed without a word")

endmodule

// ===== sim/wtvd_vote_checker.sv =====
`timescale 1ns / 100ps
// checker: watches both word channels and the register port, predicts and compares each result
module wtvd_vote_checker
    import wtvd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // instance_present, node_rank[16], parent_present, link_etx[16], rx_total[16]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // window_full, rank_rises[3], etx_rises[3], busy_ticks[3], quiet_ticks[3],
    // activate, deactivate, sink_mode
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int WLEN = WINDOW_LEN_DEF;

    typedef struct packed {
        logic [15:0] rx_total;
        logic [15:0] link_etx;
        logic        parent_present;
        logic [15:0] node_rank;
        logic        instance_present;
    } tick_t;

    typedef struct packed {
        logic       sink_mode;
        logic       deactivate;
        logic       activate;
        logic [2:0] quiet_ticks;
        logic [2:0] busy_ticks;
        logic [2:0] etx_rises;
        logic [2:0] rank_rises;
        logic       window_full;
    } verdict_t;

    logic [15:0]        rank_thr, etx_thr, rx_high, rx_low;
    logic [VOTES_W-1:0] votes_needed;

    logic        tick_seen;
    int          fill;
    logic [15:0] rank_win [WLEN];
    logic [15:0] etx_win  [WLEN];
    logic [15:0] delta_win[WLEN];
    logic [15:0] last_rx_total;
    logic        in_sink;

    verdict_t verdict_q[$];
    int       fail_count = 0;
    int       pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic verdict_t judge_tick(input tick_t t);
        verdict_t    v;
        logic [15:0] etx, delta;
        logic        was_seen;
        int          rr, er, busy, quiet, i;
        v = '0;
        rr = 0;
        er = 0;
        busy = 0;
        quiet = 0;
        was_seen = tick_seen;
        etx = t.parent_present ? t.link_etx : NO_PARENT_ETX;
        tick_seen = 1'b1;
        if (t.instance_present) begin
            delta = t.rx_total - last_rx_total;
            // the very first tick never lands in the window
            if (was_seen && fill < WLEN) begin
                rank_win[fill]  = t.node_rank;
                etx_win[fill]   = etx;
                delta_win[fill] = delta;
                fill++;
            end
            if (fill >= WLEN) begin
                v.window_full = 1'b1;
                // shift and store again, so the filling sample sits twice
                for (i = 0; i < WLEN - 1; i++) begin
                    rank_win[i]  = rank_win[i+1];
                    etx_win[i]   = etx_win[i+1];
                    delta_win[i] = delta_win[i+1];
                end
                rank_win[WLEN-1]  = t.node_rank;
                etx_win[WLEN-1]   = etx;
                delta_win[WLEN-1] = delta;
                for (i = 1; i < WLEN; i++) begin
                    if ({1'b0, rank_win[i]} >= {1'b0, rank_win[0]} + {1'b0, rank_thr}) rr++;
                    if ({1'b0, etx_win[i]} >= {1'b0, etx_win[0]} + {1'b0, etx_thr}) er++;
                end
                for (i = 0; i < WLEN; i++) begin
                    if (delta_win[i] >= rx_high) busy++;
                    if (delta_win[i] <= rx_low) quiet++;
                end
            end
            last_rx_total = t.rx_total;
            // activation wins; a cleared window blocks the quiet vote
            if (v.window_full && rr >= votes_needed && !in_sink) begin
                in_sink = 1'b1;
                v.activate = 1'b1;
                fill = 0;
            end
            if (fill >= WLEN && quiet >= votes_needed && in_sink) begin
                in_sink = 1'b0;
                v.deactivate = 1'b1;
                fill = 0;
            end
        end
        v.rank_rises  = rr[2:0];
        v.etx_rises   = er[2:0];
        v.busy_ticks  = busy[2:0];
        v.quiet_ticks = quiet[2:0];
        v.sink_mode   = in_sink;
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        verdict_t got, want;
        if (!i_rst_n) begin
            rank_thr      = RANK_THR_RST;
            etx_thr       = ETX_THR_RST;
            rx_high       = RX_HIGH_RST;
            rx_low        = RX_LOW_RST;
            votes_needed  = VOTES_RST;
            tick_seen     = 1'b0;
            fill          = 0;
            last_rx_total = '0;
            in_sink       = 1'b0;
            for (int i = 0; i < WLEN; i++) begin
                rank_win[i]  = '0;
                etx_win[i]   = '0;
                delta_win[i] = '0;
            end
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RANK_THR: rank_thr = i_cfg_data;
                    CFG_ETX_THR:  etx_thr = i_cfg_data;
                    CFG_RX_HIGH:  rx_high = i_cfg_data;
                    CFG_RX_LOW:   rx_low = i_cfg_data;
                    CFG_VOTES:    votes_needed = i_cfg_data[VOTES_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (verdict_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", int'(got), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.window_full != want.window_full)
                        report_mismatch("window_full", got.window_full, want.window_full);
                    if (got.rank_rises != want.rank_rises)
                        report_mismatch("rank_rises", got.rank_rises, want.rank_rises);
                    if (got.etx_rises != want.etx_rises)
                        report_mismatch("etx_rises", got.etx_rises, want.etx_rises);
                    if (got.busy_ticks != want.busy_ticks)
                        report_mismatch("busy_ticks", got.busy_ticks, want.busy_ticks);
                    if (got.quiet_ticks != want.quiet_ticks)
                        report_mismatch("quiet_ticks", got.quiet_ticks, want.quiet_ticks);
                    if (got.activate != want.activate)
                        report_mismatch("activate", got.activate, want.activate);
                    if (got.deactivate != want.deactivate)
                        report_mismatch("deactivate", got.deactivate, want.deactivate);
                    if (got.sink_mode != want.sink_mode)
                        report_mismatch("sink_mode", got.sink_mode, want.sink_mode);
                end
            end
            if (i_s_tvalid && i_s_tready)
                verdict_q.push_back(judge_tick(i_s_tdata[IN_BITS-1:0]));
        end
        pending = verdict_q.size();
    end

endmodule

// ===== sim/tb_windowed_trend_vote_detector_unit.sv =====
`timescale 1ns / 100ps
// testbench top: clock, reset, tick stimulus, register phases and the verdict
module tb_windowed_trend_vote_detector_unit;
    import wtvd_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count, pending;

    int          snd_idle_pct = 11;
    int          rcv_idle_pct = 73;
    int          hold_starts = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [15:0] rank_now, etx_now, rx_now, high_now, low_now;
    bit          trend_up;

    always #1 i_clk = ~i_clk;

    windowed_trend_vote_detector_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    wtvd_vote_checker vote_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random stalls, plus a long hold-off when asked for
    always @(posedge i_clk) begin
        if (hold_seen != hold_starts) begin
            hold_seen = hold_starts;
            hold_left = 120;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic offer(input logic pres, input logic [15:0] rank, input logic par,
                         input logic [15:0] etx, input logic [15:0] rx);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, rx, etx, par, rank, pres};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic offer_trend_tick();
        int          pick;
        logic [15:0] delta;
        pick = $urandom_range(99);
        if (pick < 6) begin
            // noise word
            offer(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)),
                  16'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(19) == 0) trend_up = ~trend_up;
            if (trend_up) begin
                rank_now += 16'($urandom_range(400));
                etx_now  += 16'($urandom_range(300));
            end else begin
                rank_now -= 16'($urandom_range(120));
                etx_now  -= 16'($urandom_range(100));
            end
            // falling trend leans toward quiet ticks so sink mode gets left again
            case ((!trend_up && $urandom_range(9) < 7) ? 0 : $urandom_range(3))
                0: delta = 16'($urandom_range(low_now));
                1: delta = high_now + 16'($urandom_range(40));
                2: delta = (high_now >> 1) + (low_now >> 1);
                default: delta = 16'($urandom);
            endcase
            rx_now += delta;
            offer(pick >= 10, rank_now, $urandom_range(4) != 0, etx_now, rx_now);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_thresholds(input logic [15:0] rank_thr, input logic [15:0] etx_thr,
                                      input logic [15:0] high, input logic [15:0] low,
                                      input logic [15:0] votes_word);
        write_reg(CFG_RANK_THR, rank_thr);
        write_reg(CFG_ETX_THR, etx_thr);
        write_reg(CFG_RX_HIGH, high);
        write_reg(CFG_RX_LOW, low);
        write_reg(CFG_VOTES, votes_word);
        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        high_now = high;
        low_now  = low;
    endtask

    initial begin
        int phase;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        high_now = RX_HIGH_RST;
        low_now  = RX_LOW_RST;
        trend_up = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first tick absent, then a fill with an absent tick in the middle
        offer(1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
        offer(1'b1, 16'd100, 1'b0, 16'd0, 16'd5);
        offer(1'b1, 16'd300, 1'b1, 16'd0, 16'd200);
        offer(1'b1, 16'd500, 1'b1, 16'hffff, 16'd350);
        offer(1'b0, 16'hffff, 1'b1, 16'hffff, 16'hffff);
        offer(1'b1, 16'd700, 1'b1, 16'd200, 16'd360);
        offer(1'b1, 16'd900, 1'b0, 16'hffff, 16'hffff);
        // sink mode: rank keeps rising but only quiet ticks can switch back
        offer(1'b1, 16'd1000, 1'b1, 16'd300, 16'd5);
        offer(1'b1, 16'd1200, 1'b1, 16'd300, 16'd5);
        offer(1'b1, 16'd1400, 1'b1, 16'd600, 16'd5);
        offer(1'b1, 16'd1600, 1'b1, 16'd900, 16'd8);
        offer(1'b1, 16'd1800, 1'b0, 16'd0, 16'd8);
        // rank rise and quiet votes land in the same tick
        offer(1'b1, 16'd0, 1'b1, 16'd0, 16'd8);
        offer(1'b1, 16'd200, 1'b1, 16'd100, 16'd10);
        offer(1'b1, 16'd400, 1'b1, 16'd200, 16'd10);
        offer(1'b1, 16'd600, 1'b1, 16'd300, 16'd12);
        offer(1'b1, 16'd800, 1'b1, 16'd400, 16'd12);
        offer(1'b1, 16'hffff, 1'b1, 16'hffff, 16'hffff);
        offer(1'b1, 16'd0, 1'b1, 16'd0, 16'd0);
        rank_now = 16'd0;
        etx_now  = 16'd0;
        rx_now   = 16'd0;

        for (phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin
                    snd_idle_pct = 11;
                    rcv_idle_pct = 73;
                end
                1: begin
                    snd_idle_pct = 73;
                    rcv_idle_pct = 11;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            case (phase)
                1: program_thresholds(16'($urandom_range(600)), 16'($urandom_range(600)),
                                      16'($urandom_range(100, 400)), 16'($urandom_range(60)),
                                      16'($urandom_range(1, 4)));
                2: program_thresholds('0, '0, '0, '0, '0);
                3: program_thresholds('1, '1, '1, '1, {13'h1fff, 3'd5});
                4: program_thresholds(16'($urandom_range(700)), 16'($urandom_range(500)),
                                      16'($urandom_range(60, 400)), 16'($urandom_range(60)),
                                      16'd5);
                5: program_thresholds(16'd64, 16'd256, 16'd150, 16'd15, 16'd1);
                default: ;
            endcase
            if (phase == 1) hold_starts++;
            repeat (phase == 0 ? 60 : 88) offer_trend_tick();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[windowed_trend_vote_detector_unit] OK");
        end else begin
            $display("[windowed_trend_vote_detector_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("[windowed_trend_vote_detector_unit] ERROR");
        $finish;
    end

endmodule
